[rtl/bad_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_pkg
// shared constants and types of the block average downsampler
// ----------------------------------------------------------------------------
package bad_pkg;

  // configuration register widths and the write port
  localparam int DECIM_W     = 4;
  localparam int WIDTH_W     = 13;
  localparam int HEIGHT_W    = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DECIM  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd2;

  // register reset values
  localparam logic [DECIM_W-1:0]  RESET_DECIM  = 4'd2;
  localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 13'd4096;
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd4096;

  // fixed frame height bound and output position widths
  localparam int MAX_HEIGHT = 4096;
  localparam int OUT_COL_W  = 12;
  localparam int OUT_ROW_W  = 12;

  // parameter defaults
  localparam int DEFAULT_MAX_WIDTH   = 4096;
  localparam int DEFAULT_MAX_DECIM   = 8;
  localparam int DEFAULT_SAMPLE_BITS = 16;

  // flags of one column sum update
  typedef struct packed {
    logic first_row;   // first row of a block row, memory entry is not added
    logic block_done;  // last row of the block, result goes out
    logic frame_last;  // last block of the frame
  } op_flags_t;

endpackage

[rtl/bad_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_in_if
// input sample channel: valid, ready and one sample item
// ----------------------------------------------------------------------------
interface bad_in_if #(
  parameter int SAMPLE_BITS = bad_pkg::DEFAULT_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          frame_start;

  modport source (output valid, output sample_in, output frame_start, input ready);
  modport sink   (input valid, input sample_in, input frame_start, output ready);
endinterface

[rtl/bad_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_out_if
// result channel: valid, ready and one downsampled item
// ----------------------------------------------------------------------------
interface bad_out_if #(
  parameter int SAMPLE_BITS = bad_pkg::DEFAULT_SAMPLE_BITS
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_BITS-1:0]  avg_out;
  logic [bad_pkg::OUT_COL_W-1:0]  out_col;
  logic [bad_pkg::OUT_ROW_W-1:0]  out_row;
  logic                           frame_last;

  modport source (output valid, output avg_out, output out_col, output out_row,
                  output frame_last, input ready);
  modport sink   (input valid, input avg_out, input out_col, input out_row,
                  input frame_last, output ready);
endinterface

[rtl/bad_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bad_divider #(
  parameter int NW = 13,
  parameter int DW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder
);
  localparam int CNTW = (NW > 1) ? $clog2(NW) : 1;

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   part;
  logic [NW-1:0]   quo;
  logic [DW:0]     trial;
  logic            ge;
  logic [DW-1:0]   part_next;

  always_comb begin
    trial     = {part, quo[NW-1]};
    ge        = trial >= {1'b0, divisor};
    part_next = ge ? DW'(trial - {1'b0, divisor}) : DW'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        part <= '0;
        quo  <= dividend;
      end else if (busy) begin
        part <= part_next;
        quo  <= {quo[NW-2:0], ge};
        cnt  <= cnt + CNTW'(1);
        if (cnt == CNTW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = part;
endmodule

[rtl/bad_colsum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_colsum
// column partial sum memory with read-modify-write and clearing after reset
// ----------------------------------------------------------------------------
module bad_colsum #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int SUMW  = 22,
  parameter int RW    = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  output logic                   clearing,
  input  logic                   op_valid,
  input  bad_pkg::op_flags_t     op_flags,
  input  logic [AW-1:0]          op_addr,
  input  logic signed [SUMW-1:0] op_hsum,
  input  logic [RW-1:0]          op_orow,
  output logic                   res_valid,
  output logic                   res_neg,
  output logic [SUMW-1:0]        res_mag,
  output logic [AW-1:0]          res_col,
  output logic [RW-1:0]          res_row,
  output logic                   res_last
);
  logic signed [SUMW-1:0] mem [0:DEPTH-1];

  logic [AW-1:0]          clr_addr;
  logic                   s1_valid;
  bad_pkg::op_flags_t     s1_flags;
  logic [AW-1:0]          s1_addr;
  logic signed [SUMW-1:0] s1_hsum;
  logic [RW-1:0]          s1_orow;
  logic signed [SUMW-1:0] rdata;
  logic                   fwd_hit;
  logic signed [SUMW-1:0] fwd_data;

  logic signed [SUMW-1:0] base;
  logic signed [SUMW-1:0] sum;
  logic signed [SUMW-1:0] upd;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic signed [SUMW-1:0] wdata;

  always_comb begin
    base  = fwd_hit ? fwd_data : rdata;
    sum   = s1_flags.first_row ? s1_hsum : base + s1_hsum;
    upd   = s1_flags.block_done ? '0 : sum;
    we    = clearing || (en && s1_valid);
    waddr = clearing ? clr_addr : s1_addr;
    wdata = clearing ? '0 : upd;
  end

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (en && op_valid) begin
      rdata <= mem[op_addr];
    end
  end

  // write in flight to the entry being read
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (en && op_valid) begin
      fwd_hit <= s1_valid && (s1_addr == op_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (en && op_valid) begin
      fwd_data <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= op_valid;
      res_valid <= s1_valid && s1_flags.block_done;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_flags <= op_flags;
      s1_addr  <= op_addr;
      s1_hsum  <= op_hsum;
      s1_orow  <= op_orow;
      res_neg  <= sum[SUMW-1];
      res_mag  <= sum[SUMW-1] ? SUMW'(-sum) : SUMW'(sum);
      res_col  <= s1_addr;
      res_row  <= s1_orow;
      res_last <= s1_flags.frame_last;
    end
  end
endmodule

[rtl/bad_mean.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_mean
// block sum divided by D*D through a reciprocal multiply, with output register
// ----------------------------------------------------------------------------
module bad_mean #(
  parameter int MAX_DECIM   = 8,
  parameter int SAMPLE_BITS = 16,
  parameter int SUMW        = 22,
  parameter int DW          = 4,
  parameter int AW          = 12,
  parameter int RW          = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [DW-1:0]                 d,
  input  logic                          in_valid,
  input  logic                          in_neg,
  input  logic [SUMW-1:0]               in_mag,
  input  logic [AW-1:0]                 in_col,
  input  logic [RW-1:0]                 in_row,
  input  logic                          in_last,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] avg,
  output logic [bad_pkg::OUT_COL_W-1:0] col,
  output logic [bad_pkg::OUT_ROW_W-1:0] row,
  output logic                          last
);
  localparam int L   = 2 * $clog2(MAX_DECIM);
  localparam int K   = SUMW + L;
  localparam int RTW = K + 1;
  localparam int PW  = SUMW + RTW;

  logic [RTW-1:0] recip_tab [0:MAX_DECIM];

  // ceil(2^K / (g*g)), exact for magnitudes below 2^SUMW
  for (genvar g = 0; g <= MAX_DECIM; g++) begin : g_recip
    localparam longint unsigned DD    = (g == 0) ? 1 : g * g;
    localparam longint unsigned RECIP = ((64'd1 << K) + DD - 1) / DD;
    assign recip_tab[g] = RTW'(RECIP);
  end

  logic                   s3_valid;
  logic                   s3_neg;
  logic [PW-1:0]          s3_prod;
  logic [AW-1:0]          s3_col;
  logic [RW-1:0]          s3_row;
  logic                   s3_last;
  logic [SAMPLE_BITS-1:0] quo;

  assign quo = SAMPLE_BITS'(s3_prod >> K);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s3_valid  <= in_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_neg  <= in_neg;
      s3_prod <= PW'(in_mag) * PW'(recip_tab[d]);
      s3_col  <= in_col;
      s3_row  <= in_row;
      s3_last <= in_last;
      avg     <= s3_neg ? -quo : quo;
      col     <= bad_pkg::OUT_COL_W'(s3_col);
      row     <= bad_pkg::OUT_ROW_W'(s3_row);
      last    <= s3_last;
    end
  end
endmodule

[rtl/block_average_downsampler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_average_downsampler
// box filter decimation of a raster sample stream by D by D block averages
// ----------------------------------------------------------------------------
// usage
//   pixels carries one signed Q8.8 sample per item in raster order;
//   frame_start on an item restarts the position counters at that sample.
//   results carries one block mean per D by D block, with its output column,
//   output row and a flag on the last block of the frame.
//   wr_en / wr_index / wr_data write decim_factor (0), image_width (1) and
//   image_height (2); write only while no result is pending.
// throughput and result path
//   one item per cycle while ready is high; each item that completes D samples
//   of a block row does a column sum read-modify-write, forwarded when consecutive
//   items touch the same entry; results pass the s1, res, s3 and output registers.
// reset and configuration
//   after reset the column sum memory is cleared, one entry a cycle, so ready
//   stays low until all MAX_WIDTH entries are clear. after reset and after
//   every register write the position quotients and block counts are
//   recomputed by a serial divider in 4 divisions, ready low meanwhile.
// backpressure
//   when a result waits and results.ready is low the whole pipeline holds
//   and pixels.ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module block_average_downsampler #(
  parameter int MAX_WIDTH   = bad_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_DECIM   = bad_pkg::DEFAULT_MAX_DECIM,
  parameter int SAMPLE_BITS = bad_pkg::DEFAULT_SAMPLE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  bad_in_if.sink                          pixels,
  bad_out_if.source                       results,
  input  logic                            wr_en,
  input  logic [bad_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [bad_pkg::CFG_DATA_W-1:0]  wr_data
);
  // widths
  localparam int CW   = $clog2(MAX_WIDTH);            // input column
  localparam int WW   = $clog2(MAX_WIDTH + 1);        // width and block columns
  localparam int RW   = $clog2(bad_pkg::MAX_HEIGHT);  // input row
  localparam int HW   = $clog2(bad_pkg::MAX_HEIGHT + 1);
  localparam int DW   = $clog2(MAX_DECIM + 1);        // block edge
  localparam int PW   = $clog2(MAX_DECIM);            // phase and remainder
  localparam int SUMW = SAMPLE_BITS + 2 * $clog2(MAX_DECIM);
  localparam int NW   = (WW > HW) ? WW : HW;          // divider width
  localparam int CMPW = 32;

  typedef enum logic [2:0] {
    S_DIV_COL,
    S_DIV_ROW,
    S_DIV_W,
    S_DIV_H,
    S_RUN
  } state_t;

  // configuration registers as written
  logic [bad_pkg::DECIM_W-1:0]  decim_raw;
  logic [bad_pkg::WIDTH_W-1:0]  width_raw;
  logic [bad_pkg::HEIGHT_W-1:0] height_raw;

  // clamped configuration
  logic [DW-1:0] d;
  logic [WW-1:0] w;
  logic [HW-1:0] h;

  // position state
  state_t                 state;
  logic                   div_issued;
  logic [CW-1:0]          in_col;
  logic [RW-1:0]          in_row;
  logic [PW-1:0]          col_phase;
  logic [PW-1:0]          row_phase;
  logic signed [SUMW-1:0] row_accum;
  logic [CW-1:0]          col_q;     // in_col / d
  logic [PW-1:0]          col_r;     // in_col % d
  logic [RW-1:0]          row_q;     // in_row / d
  logic [PW-1:0]          row_r;     // in_row % d
  logic [WW-1:0]          ocols;     // whole blocks per row
  logic [HW-1:0]          orows;     // whole block rows per frame

  // next position after one item
  logic [WW-1:0]          c;
  logic [HW-1:0]          r;
  logic [PW-1:0]          cp;
  logic [PW-1:0]          rp;
  logic signed [SUMW-1:0] acc;
  logic signed [SUMW-1:0] acc_sum;
  logic [CW-1:0]          cq;
  logic [PW-1:0]          cr;
  logic [RW-1:0]          rq;
  logic [PW-1:0]          rr;

  // column sum update
  logic                   op_valid;
  bad_pkg::op_flags_t     op_flags;
  logic [CW-1:0]          op_addr;
  logic signed [SUMW-1:0] op_hsum;
  logic [RW-1:0]          op_orow;

  // pipeline
  logic                   en;
  logic                   accept;
  logic                   clearing;
  logic                   res_valid;
  logic                   res_neg;
  logic [SUMW-1:0]        res_mag;
  logic [CW-1:0]          res_col;
  logic [RW-1:0]          res_row;
  logic                   res_last;

  // divider
  logic                   div_start;
  logic [NW-1:0]          div_dividend;
  logic                   div_done;
  logic [NW-1:0]          div_quo;
  logic [DW-1:0]          div_rem;

  // clamp the registers to their working ranges
  always_comb begin
    if (decim_raw == '0) begin
      d = DW'(1);
    end else if (CMPW'(decim_raw) > CMPW'(MAX_DECIM)) begin
      d = DW'(MAX_DECIM);
    end else begin
      d = DW'(decim_raw);
    end
    if (width_raw == '0) begin
      w = WW'(1);
    end else if (CMPW'(width_raw) > CMPW'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(width_raw);
    end
    if (height_raw == '0) begin
      h = HW'(1);
    end else if (CMPW'(height_raw) > CMPW'(bad_pkg::MAX_HEIGHT)) begin
      h = HW'(bad_pkg::MAX_HEIGHT);
    end else begin
      h = HW'(height_raw);
    end
  end

  // handshake: the pipeline moves unless a finished result is held up
  assign en            = !results.valid || results.ready;
  assign pixels.ready  = (state == S_RUN) && !clearing && en;
  assign accept        = pixels.valid && pixels.ready;

  // position update for one item
  always_comb begin
    c        = WW'(in_col);
    r        = HW'(in_row);
    cp       = col_phase;
    rp       = row_phase;
    acc      = row_accum;
    acc_sum  = row_accum;
    cq       = col_q;
    cr       = col_r;
    rq       = row_q;
    rr       = row_r;
    op_valid = 1'b0;
    op_flags = '0;
    op_addr  = col_q;
    op_hsum  = row_accum;
    op_orow  = row_q;

    if (pixels.frame_start) begin
      c   = '0;
      r   = '0;
      cp  = '0;
      rp  = '0;
      acc = '0;
      cq  = '0;
      cr  = '0;
      rq  = '0;
      rr  = '0;
    end

    // column beyond a narrowed width ends the row
    if (c >= w) begin
      c   = '0;
      cp  = '0;
      acc = '0;
      cq  = '0;
      cr  = '0;
      r   = r + HW'(1);
      rp  = (DW'(rp) >= d - DW'(1)) ? '0 : rp + PW'(1);
      if (DW'(rr) + DW'(1) == d) begin
        rr = '0;
        rq = rq + RW'(1);
      end else begin
        rr = rr + PW'(1);
      end
    end
    if (r >= h) begin
      r  = '0;
      rp = '0;
      rq = '0;
      rr = '0;
    end

    // samples inside a whole block only
    if (WW'(cq) < ocols && HW'(rq) < orows) begin
      acc_sum = acc + SUMW'(pixels.sample_in);
      if (DW'(cp) >= d - DW'(1)) begin
        op_valid            = 1'b1;
        op_flags.first_row  = (rp == '0);
        op_flags.block_done = (DW'(rp) >= d - DW'(1));
        op_flags.frame_last = (WW'(cq) == ocols - WW'(1)) && (HW'(rq) == orows - HW'(1));
        op_addr             = cq;
        op_hsum             = acc_sum;
        op_orow             = rq;
        acc                 = '0;
      end else begin
        acc = acc_sum;
      end
    end

    // advance one column
    cp = (DW'(cp) >= d - DW'(1)) ? '0 : cp + PW'(1);
    c  = c + WW'(1);
    if (DW'(cr) + DW'(1) == d) begin
      cr = '0;
      cq = cq + CW'(1);
    end else begin
      cr = cr + PW'(1);
    end
    if (c >= w) begin
      c   = '0;
      cp  = '0;
      acc = '0;
      cq  = '0;
      cr  = '0;
      r   = r + HW'(1);
      rp  = (DW'(rp) >= d - DW'(1)) ? '0 : rp + PW'(1);
      if (DW'(rr) + DW'(1) == d) begin
        rr = '0;
        rq = rq + RW'(1);
      end else begin
        rr = rr + PW'(1);
      end
      if (r >= h) begin
        r  = '0;
        rp = '0;
        rq = '0;
        rr = '0;
      end
    end
  end

  // divider operand for the current recompute step
  assign div_start = (state != S_RUN) && !div_issued;

  always_comb begin
    unique case (state)
      S_DIV_COL: div_dividend = NW'(in_col);
      S_DIV_ROW: div_dividend = NW'(in_row);
      S_DIV_W:   div_dividend = NW'(w);
      S_DIV_H:   div_dividend = NW'(h);
      default:   div_dividend = '0;
    endcase
  end

  // control, position state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_DIV_COL;
      div_issued <= 1'b0;
      in_col     <= '0;
      in_row     <= '0;
      col_phase  <= '0;
      row_phase  <= '0;
      row_accum  <= '0;
      col_q      <= '0;
      col_r      <= '0;
      row_q      <= '0;
      row_r      <= '0;
      ocols      <= '0;
      orows      <= '0;
      decim_raw  <= bad_pkg::RESET_DECIM;
      width_raw  <= bad_pkg::RESET_WIDTH;
      height_raw <= bad_pkg::RESET_HEIGHT;
    end else begin
      if (div_start) begin
        div_issued <= 1'b1;
      end
      unique case (state)
        S_DIV_COL: begin
          if (div_issued && div_done) begin
            col_q      <= CW'(div_quo);
            col_r      <= PW'(div_rem);
            div_issued <= 1'b0;
            state      <= S_DIV_ROW;
          end
        end
        S_DIV_ROW: begin
          if (div_issued && div_done) begin
            row_q      <= RW'(div_quo);
            row_r      <= PW'(div_rem);
            div_issued <= 1'b0;
            state      <= S_DIV_W;
          end
        end
        S_DIV_W: begin
          if (div_issued && div_done) begin
            ocols      <= WW'(div_quo);
            div_issued <= 1'b0;
            state      <= S_DIV_H;
          end
        end
        S_DIV_H: begin
          if (div_issued && div_done) begin
            orows      <= HW'(div_quo);
            div_issued <= 1'b0;
            state      <= S_RUN;
          end
        end
        S_RUN: begin
          if (accept) begin
            in_col    <= CW'(c);
            in_row    <= RW'(r);
            col_phase <= cp;
            row_phase <= rp;
            row_accum <= acc;
            col_q     <= cq;
            col_r     <= cr;
            row_q     <= rq;
            row_r     <= rr;
          end
        end
        default: begin
          state <= S_DIV_COL;
        end
      endcase

      // a register write restarts the recompute
      if (wr_en) begin
        unique case (wr_index)
          bad_pkg::REG_DECIM:  decim_raw  <= bad_pkg::DECIM_W'(wr_data);
          bad_pkg::REG_WIDTH:  width_raw  <= bad_pkg::WIDTH_W'(wr_data);
          bad_pkg::REG_HEIGHT: height_raw <= bad_pkg::HEIGHT_W'(wr_data);
          default: ;
        endcase
        state      <= S_DIV_COL;
        div_issued <= 1'b0;
      end
    end
  end

  bad_divider #(
    .NW (NW),
    .DW (DW)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (d),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  bad_colsum #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .SUMW  (SUMW),
    .RW    (RW)
  ) u_colsum (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .clearing  (clearing),
    .op_valid  (op_valid && accept),
    .op_flags  (op_flags),
    .op_addr   (op_addr),
    .op_hsum   (op_hsum),
    .op_orow   (op_orow),
    .res_valid (res_valid),
    .res_neg   (res_neg),
    .res_mag   (res_mag),
    .res_col   (res_col),
    .res_row   (res_row),
    .res_last  (res_last)
  );

  bad_mean #(
    .MAX_DECIM   (MAX_DECIM),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUMW        (SUMW),
    .DW          (DW),
    .AW          (CW),
    .RW          (RW)
  ) u_mean (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .d         (d),
    .in_valid  (res_valid),
    .in_neg    (res_neg),
    .in_mag    (res_mag),
    .in_col    (res_col),
    .in_row    (res_row),
    .in_last   (res_last),
    .out_valid (results.valid),
    .avg       (results.avg_out),
    .col       (results.out_col),
    .row       (results.out_row),
    .last      (results.frame_last)
  );
endmodule

[tb/bad_block_mean_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_block_mean_checker
// watches the sample, result and register ports of the downsampler, works
// out the block mean of every completed block and compares each result
// ----------------------------------------------------------------------------
module bad_block_mean_checker
  import bad_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  bad_in_if                      pixels,
  bad_out_if                     results,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  output int                     fail_count,
  output int                     pending_count
);

  localparam int SAMPLE_W = DEFAULT_SAMPLE_BITS;
  localparam int SUM_W    = 22;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] avg;
    logic [OUT_COL_W-1:0]       col;
    logic [OUT_ROW_W-1:0]       row;
    logic                       last;
  } block_mean_t;

  block_mean_t expected_means[$];

  // mirrored block state
  logic signed [SUM_W-1:0] col_sums [DEFAULT_MAX_WIDTH];
  logic signed [SUM_W-1:0] row_sum;
  logic [WIDTH_W-1:0]      col_pos;
  logic [HEIGHT_W-1:0]     row_pos;
  logic [2:0]              col_ph;
  logic [2:0]              row_ph;
  logic [DECIM_W-1:0]      decim_reg;
  logic [WIDTH_W-1:0]      width_reg;
  logic [HEIGHT_W-1:0]     height_reg;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // zero counts as one, anything above the bound saturates
  function automatic int bounded(input int v, input int hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  // end of row and end of frame wrap, also after a register change
  function automatic void settle_position(input int d, input int w, input int h);
    if (col_pos >= w) begin
      col_pos = '0;
      col_ph  = '0;
      row_sum = '0;
      row_pos = row_pos + 1'b1;
      row_ph  = (row_ph >= d - 1) ? 3'd0 : row_ph + 3'd1;
    end
    if (row_pos >= h) begin
      row_pos = '0;
      row_ph  = '0;
    end
  endfunction

  function automatic void advance_block_mean(input logic signed [SAMPLE_W-1:0] smp,
                                             input logic fs);
    int d, w, h, oc, orow, sum;
    block_mean_t mean;
    d = bounded(decim_reg, DEFAULT_MAX_DECIM);
    w = bounded(width_reg, DEFAULT_MAX_WIDTH);
    h = bounded(height_reg, MAX_HEIGHT);
    if (fs) begin
      col_pos = '0;
      row_pos = '0;
      col_ph  = '0;
      row_ph  = '0;
      row_sum = '0;
    end
    settle_position(d, w, h);
    // leftover columns and rows take no part
    if (col_pos < (w / d) * d && row_pos < (h / d) * d) begin
      row_sum = row_sum + smp;
      if (col_ph >= d - 1) begin
        oc      = (col_pos / d) % DEFAULT_MAX_WIDTH;
        orow    = row_pos / d;
        sum     = ((row_ph == 0) ? 0 : int'(col_sums[oc])) + int'(row_sum);
        row_sum = '0;
        if (row_ph >= d - 1) begin
          mean.avg  = SAMPLE_W'(sum / (d * d));
          mean.col  = OUT_COL_W'(oc);
          mean.row  = OUT_ROW_W'(orow);
          mean.last = (oc == w / d - 1) && (orow == h / d - 1);
          expected_means.push_back(mean);
          col_sums[oc] = '0;
        end else begin
          col_sums[oc] = SUM_W'(sum);
        end
      end
    end
    col_ph  = (col_ph >= d - 1) ? 3'd0 : col_ph + 3'd1;
    col_pos = col_pos + 1'b1;
    settle_position(d, w, h);
  endfunction

  function automatic void report_field(input string field, input int want, input int got);
    $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    fail_count++;
  endfunction

  function automatic void check_block_mean();
    block_mean_t mean;
    if (expected_means.size() == 0) begin
      $display("%0t: unexpected result avg_out %0d out_col %0d out_row %0d frame_last %0b",
               $time, results.avg_out, results.out_col, results.out_row, results.frame_last);
      fail_count++;
    end else begin
      mean = expected_means.pop_front();
      if (results.avg_out !== mean.avg)
        report_field("avg_out", mean.avg, results.avg_out);
      if (results.out_col !== mean.col)
        report_field("out_col", mean.col, results.out_col);
      if (results.out_row !== mean.row)
        report_field("out_row", mean.row, results.out_row);
      if (results.frame_last !== mean.last)
        report_field("frame_last", mean.last, results.frame_last);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEFAULT_MAX_WIDTH; i++) col_sums[i] = '0;
      row_sum    = '0;
      col_pos    = '0;
      row_pos    = '0;
      col_ph     = '0;
      row_ph     = '0;
      decim_reg  = RESET_DECIM;
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      expected_means.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_DECIM:  decim_reg  = wr_data[DECIM_W-1:0];
          REG_WIDTH:  width_reg  = wr_data[WIDTH_W-1:0];
          REG_HEIGHT: height_reg = wr_data[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (pixels.valid && pixels.ready)
        advance_block_mean(pixels.sample_in, pixels.frame_start);
      if (results.valid && results.ready)
        check_block_mean();
    end
    pending_count = expected_means.size();
  end

endmodule

[tb/tb_block_average_downsampler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_average_downsampler
// drives raster sample streams through the block average downsampler under
// a series of decimation factors and frame sizes, with random bursts on the
// input and random stalls on the output; a side checker predicts every
// block mean and compares it with what comes out
// ----------------------------------------------------------------------------
module tb_block_average_downsampler;
  import bad_pkg::*;

  localparam int SAMPLE_W     = DEFAULT_SAMPLE_BITS;
  localparam int RANDOM_ITEMS = 900;
  localparam int PHASE_CAP    = 160;     // items per random phase at most
  localparam int DRAIN_CYCLES = 16;      // drain wait, with margin over the pipeline depth
  localparam int HOLD_CYCLES  = 400;     // one long output stall
  localparam int CYCLE_LIMIT  = 200000;

  // receiver stall patterns
  typedef enum int {
    DRAIN_FREE,
    DRAIN_HALF,
    DRAIN_SPARSE,
    DRAIN_PATTERN
  } drain_mode_e;

  logic                   clk;
  logic                   rst;
  logic                   wr_en;
  logic [CFG_INDEX_W-1:0] wr_index;
  logic [CFG_DATA_W-1:0]  wr_data;
  int                     fail_count;
  int                     pending_count;
  int                     cycle_count = 0;
  int                     burst_left  = 0;
  bit                     gaps_on     = 1'b1;
  bit                     hold_request = 1'b0;

  bad_in_if  pixels ();
  bad_out_if results ();

  block_average_downsampler uut (
    .clk      (clk),
    .rst      (rst),
    .pixels   (pixels),
    .results  (results),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  bad_block_mean_checker mean_chk (
    .clk           (clk),
    .rst           (rst),
    .pixels        (pixels),
    .results       (results),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog against a hung handshake or a lost result
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("block_average_downsampler test failed");
      $finish;
    end
  end

  // zero counts as one, anything above the bound saturates
  function automatic int bounded(input int v, input int hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  // mix of full-scale extremes, values near zero for the truncation and
  // plain random words so every sample bit toggles
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1, 2:    return SAMPLE_W'($signed($urandom_range(0, 16)) - 8);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // offer one item and hold it until taken; the sender runs in bursts and
  // pauses between them while gaps are on; in a burst valid stays high item to item
  task automatic send_item(input logic signed [SAMPLE_W-1:0] smp, input logic fs);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        pixels.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    pixels.valid       <= 1'b1;
    pixels.sample_in   <= smp;
    pixels.frame_start <= fs;
    burst_left--;
    @(posedge clk);
    while (!pixels.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // registers change only with nothing in flight: wait for the last block
  // mean, then for the items that close no block to leave the pipeline
  task automatic write_config(input logic [CFG_DATA_W-1:0] decim,
                              input logic [CFG_DATA_W-1:0] width,
                              input logic [CFG_DATA_W-1:0] height);
    pixels.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= REG_DECIM;
    wr_data  <= decim;
    @(negedge clk);
    wr_index <= REG_WIDTH;
    wr_data  <= width;
    @(negedge clk);
    wr_index <= REG_HEIGHT;
    wr_data  <= height;
    @(negedge clk);
    wr_en    <= 1'b0;
  endtask

  // result side: the stall pattern changes at random intervals, one long
  // hold while the sender keeps pushing so the block backs up
  initial begin : result_drain
    drain_mode_e mode;
    int          mode_left;
    int          tick;
    bit          held;
    mode          = DRAIN_FREE;
    mode_left     = 0;
    tick          = 0;
    held          = 1'b0;
    results.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request && !held) begin
        held = 1'b1;
        results.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode      = drain_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      tick++;
      case (mode)
        DRAIN_FREE:   results.ready <= 1'b1;
        DRAIN_HALF:   results.ready <= $urandom_range(0, 1);
        DRAIN_SPARSE: results.ready <= ($urandom_range(0, 3) == 0);
        default:      results.ready <= (tick % 3 != 0);
      endcase
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic signed [SAMPLE_W-1:0] first_frame [15];
    logic [CFG_DATA_W-1:0]      dv, wv, hv;
    int                         sent, phase, ed, ew, eh, fsize, total;
    bit                         fresh, fs;

    rst                = 1'b1;
    wr_en              = 1'b0;
    wr_index           = REG_DECIM;
    wr_data            = '0;
    pixels.valid       = 1'b0;
    pixels.sample_in   = '0;
    pixels.frame_start = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // 2x2 blocks on a 5x3 frame: the fifth column and third row are left
    // over; first block is all positive full scale, second holds a single
    // -1 whose quarter must truncate toward zero, not down to -1
    first_frame = '{16'sh7fff, 16'sh7fff, -1, 0, 7,
                    16'sh7fff, 16'sh7fff, 0, 0, -5,
                    16'sh0100, 16'sh0200, 16'sh0300, 16'sh0400, 16'sh0500};
    write_config(2, 5, 3);
    foreach (first_frame[i]) send_item(first_frame[i], i == 0);

    // factor, width and height of zero all act as one: every sample is its
    // own block and the last of its frame
    write_config(0, 0, 0);
    send_item(16'sh8000, 1'b1);
    send_item(1, 1'b0);

    // 3x3 block of negative full scale, the most negative mean
    write_config(3, 3, 3);
    for (int i = 0; i < 9; i++) send_item(16'sh8000, i == 0);

    // random phases: mostly whole frames with random content, some phases
    // pick up mid-frame after the register change, stray frame starts
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 0) begin
        // one result per item, so the long output hold fills the block
        dv = 1;
        wv = 6;
        hv = 4;
      end else if (phase == 1) begin
        // largest factor with leftovers on both edges
        dv = 8;
        wv = 17;
        hv = 9;
      end else begin
        case ($urandom_range(0, 9))
          0:       dv = 0;
          1:       dv = $urandom_range(9, 15);
          default: dv = $urandom_range(1, 8);
        endcase
        ed = bounded(dv, DEFAULT_MAX_DECIM);
        case ($urandom_range(0, 11))
          0:       wv = 0;
          1:       wv = $urandom_range(4097, 8191);
          2:       wv = 4096;
          default: wv = ed * $urandom_range(1, 5) + $urandom_range(0, ed - 1);
        endcase
        case ($urandom_range(0, 11))
          0:       hv = 0;
          1:       hv = 8191;
          default: hv = ed * $urandom_range(1, 4) + $urandom_range(0, ed - 1);
        endcase
      end
      ew = bounded(wv, DEFAULT_MAX_WIDTH);
      eh = bounded(hv, MAX_HEIGHT);
      write_config(dv, wv, hv);
      gaps_on = ($urandom_range(0, 3) != 0);
      if (phase == 0) hold_request = 1'b1;
      fsize = ew * eh;
      total = fsize * $urandom_range(1, 3);
      if (total > PHASE_CAP) total = PHASE_CAP;
      fresh = (phase < 2) || ($urandom_range(0, 3) != 0);
      for (int i = 0; i < total; i++) begin
        fs = (i % fsize == 0) && (i > 0 || fresh);
        // stray frame start in the middle of a frame
        if ($urandom_range(0, 29) == 0) fs = 1'b1;
        send_item(rand_sample(), fs);
      end
      sent += total;
      phase++;
    end

    // let everything drain, then wait out the drain margin to catch a stray result
    pixels.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("block_average_downsampler test passed");
    end else begin
      $display("block_average_downsampler test failed");
    end
    $finish;
  end

endmodule
